@@ rtl/core/mbdc_pkg.sv @@
// Shared constants for the multi-bit debounce and change detector.
// Used by the top level; depends on nothing else.
package mbdc_pkg;

    localparam int NUM_BYTES     = 16;
    localparam int BITS_PER_BYTE = 8;
    localparam int TIME_W        = 32;
    localparam int IDX_IN_W      = 4;
    localparam int BIT_NUM_W     = 7;
    localparam int ADDR_W        = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
    localparam int ROW_W         = BITS_PER_BYTE + BITS_PER_BYTE * TIME_W;

endpackage

@@ rtl/core/mbdc_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; the read holds its data while the read enable is low.
module mbdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/multi_bit_debounce_change_detect.sv @@
// Top level of the multi-bit debounce and change detector.
// Depends on mbdc_pkg and mbdc_ram.

// A word is one scanned byte of active-low pins with its byte index and a
// timestamp. Each byte has one RAM row that holds its accepted level and
// the last accepted toggle time of each of its eight bits. A word is read
// from the RAM in the cycle it is accepted, checked against the lockout
// and written back when it leaves that stage, with the last write
// forwarded when the next word hits the same row. A new word can be
// accepted every cycle while that stage can advance, and its events are
// registered in the event stage as it leaves. The event output sends one
// event per cycle while i_out_ready is high, k events for a byte with k
// accepted changes. Reset takes effect at once through per-row valid bits.
module multi_bit_debounce_change_detect
    import mbdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [TIME_W-1:0]     i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [IDX_IN_W-1:0]   i_byte_index,
    input  logic [7:0]            i_pin_levels,
    input  logic [TIME_W-1:0]     i_timestamp,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [BIT_NUM_W-1:0]  o_bit_number,
    output logic                  o_new_level,
    output logic                  o_last_of_run
);

    logic [TIME_W-1:0]        r_lockout;
    logic [NUM_BYTES-1:0]     r_row_vld;

    logic                     r_s1_vld;
    logic [IDX_IN_W-1:0]      r_s1_idx;
    logic [ADDR_W-1:0]        r_s1_addr;
    logic [7:0]               r_s1_cur;
    logic [TIME_W-1:0]        r_s1_now;
    logic                     r_s1_rv;

    logic                     r_lw_vld;
    logic [ADDR_W-1:0]        r_lw_addr;
    logic [ROW_W-1:0]         r_lw_data;

    logic                     r_em_vld;
    logic [7:0]               r_em_mask;
    logic [7:0]               r_em_lvl;
    logic [IDX_IN_W-1:0]      r_em_idx;

    logic                     in_acc;
    logic                     idx_ok;
    logic [ADDR_W-1:0]        in_addr;
    logic [ROW_W-1:0]         ram_rdata;
    logic [ROW_W-1:0]         row;
    logic [ROW_W-1:0]         n_row;
    logic [7:0]               prev;
    logic [7:0]               changed;
    logic [7:0]               revert;
    logic [7:0]               result;
    logic [7:0]               survived;
    logic                     em_free;
    logic                     s1_adv;
    logic [7:0]               n_em_mask;
    logic [2:0]               em_bit;

    assign idx_ok  = int'(i_byte_index) < NUM_BYTES;
    assign in_addr = ADDR_W'(i_byte_index);
    assign in_acc  = i_in_valid && o_in_ready;

    mbdc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_addr),
        .i_wdata (n_row),
        .i_re    (in_acc),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_lw_vld && (r_lw_addr == r_s1_addr)) begin
            row = r_lw_data;
        end else if (r_s1_rv) begin
            row = ram_rdata;
        end else begin
            row = '0;
        end
        prev    = row[7:0];
        changed = r_s1_cur ^ prev;
        n_row   = row;
        revert  = '0;
        for (int j = 0; j < BITS_PER_BYTE; j++) begin
            if (changed[j]) begin
                if ((r_s1_now - row[BITS_PER_BYTE + j*TIME_W +: TIME_W]) < r_lockout) begin
                    revert[j] = 1'b1;
                end else begin
                    n_row[BITS_PER_BYTE + j*TIME_W +: TIME_W] = r_s1_now;
                end
            end
        end
        result     = (r_s1_cur & ~revert) | (prev & revert);
        survived   = result ^ prev;
        n_row[7:0] = result;
    end

    assign n_em_mask = r_em_mask & (r_em_mask - 8'd1);
    assign em_free   = !r_em_vld || (i_out_ready && (n_em_mask == '0));
    assign s1_adv    = r_s1_vld && (em_free || (survived == '0));
    assign o_in_ready = !r_s1_vld || s1_adv;

    always_comb begin
        em_bit = '0;
        for (int j = BITS_PER_BYTE - 1; j >= 0; j--) begin
            if (r_em_mask[j]) begin
                em_bit = 3'(j);
            end
        end
    end

    assign o_out_valid   = r_em_vld;
    assign o_bit_number  = BIT_NUM_W'(r_em_idx) * BIT_NUM_W'(BITS_PER_BYTE) + BIT_NUM_W'(em_bit);
    assign o_new_level   = r_em_lvl[em_bit];
    assign o_last_of_run = (n_em_mask == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout <= '0;
            r_row_vld <= '0;
            r_s1_vld  <= 1'b0;
            r_lw_vld  <= 1'b0;
            r_em_vld  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_lockout <= i_cfg_wr_data;
            end
            if (in_acc && idx_ok) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_row_vld[r_s1_addr] <= 1'b1;
                r_lw_vld             <= 1'b1;
            end
            if (s1_adv && (survived != '0)) begin
                r_em_vld <= 1'b1;
            end else if (r_em_vld && i_out_ready) begin
                r_em_vld <= (n_em_mask != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_idx  <= i_byte_index;
            r_s1_addr <= in_addr;
            r_s1_cur  <= ~i_pin_levels;
            r_s1_now  <= i_timestamp;
            r_s1_rv   <= r_row_vld[in_addr];
        end
        if (s1_adv) begin
            r_lw_addr <= r_s1_addr;
            r_lw_data <= n_row;
        end
        if (s1_adv && (survived != '0)) begin
            r_em_mask <= survived;
            r_em_lvl  <= result;
            r_em_idx  <= r_s1_idx;
        end else if (r_em_vld && i_out_ready) begin
            r_em_mask <= n_em_mask;
        end
    end

endmodule

@@ test/mbdc_checker.sv @@
`timescale 1ns / 1ps
// Checker for the multi-bit debounce and change detector: mirrors the lockout
// register, predicts the change events of every accepted word and compares them.
// Depends on mbdc_pkg only.
module mbdc_checker
    import mbdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [TIME_W-1:0]     i_cfg_wr_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [IDX_IN_W-1:0]   i_byte_index,
    input  logic [7:0]            i_pin_levels,
    input  logic [TIME_W-1:0]     i_timestamp,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [BIT_NUM_W-1:0]  i_bit_number,
    input  logic                  i_new_level,
    input  logic                  i_last_of_run,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [BIT_NUM_W-1:0] bit_number;
        logic                 new_level;
        logic                 last_of_run;
    } t_change_event;

    logic [TIME_W-1:0] lockout_ticks;
    logic [7:0]        accepted_levels [0:NUM_BYTES-1];
    logic [TIME_W-1:0] toggle_stamps [0:NUM_BYTES*BITS_PER_BYTE-1];
    t_change_event     pending_events [$];

    task automatic report_mismatch(input string field, input int got, input int want);
        if (o_fail_count < 200) begin
            $display("%0t ns: event %s is %0d, expected %0d", $time, field, got, want);
        end
        o_fail_count++;
    endtask

    task automatic debounce_byte(input logic [IDX_IN_W-1:0] idx, input logic [7:0] pins,
                                 input logic [TIME_W-1:0] now);
        logic [7:0]        level;
        logic [7:0]        prev;
        logic [7:0]        held;
        logic [7:0]        result;
        logic [7:0]        flips;
        logic [TIME_W-1:0] age;
        int                slot;
        int                total;
        int                seen;
        int                j;
        t_change_event     ev;
        if (idx < NUM_BYTES) begin
            level = ~pins;
            prev = accepted_levels[idx];
            held = '0;
            for (j = 0; j < BITS_PER_BYTE; j++) begin
                slot = idx * BITS_PER_BYTE + j;
                if (level[j] != prev[j]) begin
                    age = now - toggle_stamps[slot];
                    if (age < lockout_ticks) begin
                        held[j] = 1'b1;
                    end else begin
                        toggle_stamps[slot] = now;
                    end
                end
            end
            result = (level & ~held) | (prev & held);
            flips = result ^ prev;
            total = $countones(flips);
            seen = 0;
            for (j = 0; j < BITS_PER_BYTE; j++) begin
                if (flips[j]) begin
                    seen++;
                    ev.bit_number = BIT_NUM_W'(idx * BITS_PER_BYTE + j);
                    ev.new_level = result[j];
                    ev.last_of_run = (seen == total);
                    pending_events.push_back(ev);
                end
            end
            accepted_levels[idx] = result;
        end
    endtask

    task automatic check_event();
        t_change_event want;
        if (pending_events.size() == 0) begin
            report_mismatch("with none expected, bit_number", i_bit_number, 0);
        end else begin
            want = pending_events.pop_front();
            if (i_bit_number !== want.bit_number) begin
                report_mismatch("bit_number", i_bit_number, want.bit_number);
            end
            if (i_new_level !== want.new_level) begin
                report_mismatch("new_level", i_new_level, want.new_level);
            end
            if (i_last_of_run !== want.last_of_run) begin
                report_mismatch("last_of_run", i_last_of_run, want.last_of_run);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lockout_ticks = '0;
            for (int k = 0; k < NUM_BYTES; k++) begin
                accepted_levels[k] = '0;
            end
            for (int k = 0; k < NUM_BYTES * BITS_PER_BYTE; k++) begin
                toggle_stamps[k] = '0;
            end
            pending_events.delete();
        end else begin
            if (i_cfg_wr_en) begin
                lockout_ticks = i_cfg_wr_data;
            end
            if (i_in_valid && i_in_ready) begin
                debounce_byte(i_byte_index, i_pin_levels, i_timestamp);
            end
            if (i_out_valid && i_out_ready) begin
                check_event();
            end
        end
        o_pending = pending_events.size();
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the debounce and change detector testbench: clock, reset, stimulus,
// idling and verdict. Depends on mbdc_pkg, mbdc_checker and the block itself.
module tb_top
    import mbdc_pkg::*;
();

    localparam int STALL_LIMIT = 400;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [TIME_W-1:0]    i_cfg_wr_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [IDX_IN_W-1:0]  i_byte_index;
    logic [7:0]           i_pin_levels;
    logic [TIME_W-1:0]    i_timestamp;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [BIT_NUM_W-1:0] o_bit_number;
    logic                 o_new_level;
    logic                 o_last_of_run;

    int                   fail_count;
    int                   pending;
    logic                 quiet_run;
    logic [TIME_W-1:0]    now_ticks;
    logic [7:0]           last_pins [0:NUM_BYTES-1];

    multi_bit_debounce_change_detect DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_byte_index  (i_byte_index),
        .i_pin_levels  (i_pin_levels),
        .i_timestamp   (i_timestamp),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_bit_number  (o_bit_number),
        .o_new_level   (o_new_level),
        .o_last_of_run (o_last_of_run)
    );

    mbdc_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_byte_index  (i_byte_index),
        .i_pin_levels  (i_pin_levels),
        .i_timestamp   (i_timestamp),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_bit_number  (o_bit_number),
        .i_new_level   (o_new_level),
        .i_last_of_run (o_last_of_run),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet_run && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(0, 7)) @(negedge i_clk);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_wr_en) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_word(input logic [IDX_IN_W-1:0] idx, input logic [7:0] pins,
                             input logic [TIME_W-1:0] ts);
        if (!quiet_run && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_byte_index <= idx;
        i_pin_levels <= pins;
        i_timestamp  <= ts;
        last_pins[idx] = pins;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain_events();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_lockout(input logic [TIME_W-1:0] ticks);
        drain_events();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= ticks;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_random_words(input logic [TIME_W-1:0] ticks, input int count);
        logic [IDX_IN_W-1:0] idx;
        logic [7:0]          pins;
        logic [TIME_W-1:0]   step;
        write_lockout(ticks);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 3) == 0) begin
                idx = IDX_IN_W'($urandom_range(0, NUM_BYTES - 1));
            end else begin
                idx = IDX_IN_W'($urandom_range(0, 3));
            end
            if ($urandom_range(0, 1) == 0) begin
                pins = 8'($urandom_range(0, 255));
            end else begin
                pins = last_pins[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            if (ticks <= 8) begin
                step = $urandom_range(0, 2);
            end else if (ticks >= 32'h1000_0000) begin
                step = $urandom();
            end else begin
                step = $urandom_range(0, ticks / 3);
            end
            now_ticks = now_ticks + step;
            send_word(idx, pins, now_ticks);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_byte_index  = '0;
        i_pin_levels  = 8'hFF;
        i_timestamp   = '0;
        quiet_run     = 1'b0;
        now_ticks     = '0;
        for (int k = 0; k < NUM_BYTES; k++) begin
            last_pins[k] = 8'hFF;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // With no lockout every change gets through.
        write_lockout(32'd0);
        send_word(4'd0, 8'hFF, 32'd0);
        send_word(4'd0, 8'h00, 32'd5);
        send_word(4'd0, 8'hFF, 32'd6);
        send_word(4'd15, 8'h7F, 32'hFFFF_FFFF);
        send_word(4'd15, 8'hFE, 32'h8000_0000);
        send_word(4'd5, 8'hAA, 32'h5555_5555);
        send_word(4'd10, 8'h55, 32'hAAAA_AAAA);

        // Reverted, accepted and mixed bytes, then a toggle across the time wrap.
        write_lockout(32'd1000);
        send_word(4'd3, 8'hF0, 32'd100);
        send_word(4'd3, 8'hF0, 32'd1000);
        send_word(4'd3, 8'hFF, 32'd1500);
        send_word(4'd3, 8'h3C, 32'd1999);
        send_word(4'd7, 8'hFE, 32'hFFFF_FF00);
        send_word(4'd7, 8'hFF, 32'h0000_0100);
        send_word(4'd7, 8'hFF, 32'h0000_0400);

        // Full-scale lockout only lets an age of all ones through.
        write_lockout(32'hFFFF_FFFF);
        send_word(4'd9, 8'h00, 32'hFFFF_FFFE);
        send_word(4'd9, 8'h00, 32'hFFFF_FFFF);
        send_word(4'd9, 8'hFF, 32'hFFFF_FFFF);

        now_ticks = 32'd2000;
        run_random_words($urandom_range(200, 2000), 30);
        run_random_words(32'd1, 30);
        run_random_words($urandom(), 30);
        quiet_run = 1'b1;
        run_random_words(32'd0, 30);

        drain_events();
        repeat (12) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ multi_bit_debounce_change_detect.f @@
rtl/core/mbdc_pkg.sv
rtl/core/mbdc_ram.sv
rtl/core/multi_bit_debounce_change_detect.sv
test/mbdc_checker.sv
test/tb_top.sv
